// ===== rtl/core/pol_pkg.sv =====
// pol_pkg: shared constants, command and status codes, and the cell control
// struct for the positional ordered list. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int ST_W     = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM_POS  = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // Shift control broadcast to every cell of the row
  typedef struct packed {
    logic             ins;  // open a slot at 'at', cells above shift up
    logic             rem;  // drop cell 'at', cells above shift down
    logic [IDX_W-1:0] at;
  } pol_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pol_cell.sv =====
// pol_cell: one entry of the shifting row; takes its left or right neighbor,
// the new value, or holds. Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_cell (
  input  wire logic                      clk,
  input  wire logic [pol_pkg::IDX_W-1:0] cell_idx,
  input  wire pol_pkg::pol_ctl_t         ctl,
  input  wire logic [pol_pkg::VAL_W-1:0] ins_value,
  input  wire logic [pol_pkg::VAL_W-1:0] left_data,
  input  wire logic [pol_pkg::VAL_W-1:0] right_data,
  output logic      [pol_pkg::VAL_W-1:0] data_r
);

  logic [pol_pkg::VAL_W-1:0] data_nxt;

  // Shift selection for this cell's place in the row
  always_comb begin
    data_nxt = data_r;
    if (ctl.rem && (cell_idx >= ctl.at)) begin
      data_nxt = right_data;
    end else if (ctl.ins && (cell_idx > ctl.at)) begin
      data_nxt = left_data;
    end else if (ctl.ins && (cell_idx == ctl.at)) begin
      data_nxt = ins_value;
    end
  end

  // Entry storage, no reset: only cells below the count are ever read
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pol_ctrl.sv =====
// pol_ctrl: decodes a command against the current count into the row's
// shift control, the status and the next count. Depends on pol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pol_ctrl (
  input  wire logic [pol_pkg::CMD_W-1:0] cmd,
  input  wire logic [pol_pkg::POS_W-1:0] position,
  input  wire logic [pol_pkg::CNT_W-1:0] count,
  output pol_pkg::pol_ctl_t              ctl,
  output logic                           is_remove,
  output logic      [pol_pkg::ST_W-1:0]  status,
  output logic      [pol_pkg::CNT_W-1:0] count_nxt
);

  localparam logic [pol_pkg::CNT_W-1:0] CAP_CNT = pol_pkg::CNT_W'(pol_pkg::CAPACITY);

  logic                      is_insert;
  logic [pol_pkg::CNT_W-1:0] at_pos;
  logic                      full;
  logic                      empty;

  // Target position per command
  always_comb begin
    is_insert = 1'b0;
    is_remove = 1'b0;
    at_pos    = '0;
    case (cmd)
      pol_pkg::CMD_INS_HEAD: begin
        is_insert = 1'b1;
      end
      pol_pkg::CMD_INS_TAIL: begin
        is_insert = 1'b1;
        at_pos    = count;
      end
      pol_pkg::CMD_INS_POS: begin
        is_insert = 1'b1;
        at_pos    = pol_pkg::CNT_W'(position);
      end
      pol_pkg::CMD_REM_HEAD: begin
        is_remove = 1'b1;
      end
      pol_pkg::CMD_REM_TAIL: begin
        is_remove = 1'b1;
        at_pos    = empty ? '0 : count - 1'b1;
      end
      pol_pkg::CMD_REM_POS: begin
        is_remove = 1'b1;
        at_pos    = pol_pkg::CNT_W'(position);
      end
      default: begin
      end
    endcase
  end

  assign full  = (count >= CAP_CNT);
  assign empty = (count == '0);

  // Checks in order: full or empty first, then range
  always_comb begin
    status    = pol_pkg::ST_OK;
    count_nxt = count;
    ctl.ins   = 1'b0;
    ctl.rem   = 1'b0;
    ctl.at    = at_pos[pol_pkg::IDX_W-1:0];
    if (is_insert) begin
      if (full) begin
        status = pol_pkg::ST_FULL;
      end else if (at_pos > count) begin
        status = pol_pkg::ST_RANGE;
      end else begin
        ctl.ins   = 1'b1;
        count_nxt = count + 1'b1;
      end
    end else if (is_remove) begin
      if (empty) begin
        status = pol_pkg::ST_EMPTY;
      end else if (at_pos >= count) begin
        status = pol_pkg::ST_RANGE;
      end else begin
        ctl.rem   = 1'b1;
        count_nxt = count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/positional_ordered_list_unit.sv =====
// Positional ordered list: a row of 16 shifting cells holding signed 32-bit
// values, with the decode unit and result register. Depends on pol_pkg,
// pol_ctrl and pol_cell.
//
// Each command (insert or remove at head, tail or a given position) shifts the
// whole cell row in the cycle its beat is accepted, so a new command can be
// taken every cycle while the result register is free. The result beat
// (removed value, status, new count) appears in the output register the cycle
// after acceptance and a new input beat is taken while it waits, as long as
// out_ready frees that register in the same cycle. Failed commands leave the
// list unchanged. There is no clearing pass: the list is empty right after reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic        [pol_pkg::CMD_W-1:0] in_cmd,
  input  wire logic signed [pol_pkg::VAL_W-1:0] in_value_in,
  input  wire logic        [pol_pkg::POS_W-1:0] in_position,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed      [pol_pkg::VAL_W-1:0] out_value_out,
  output logic             [pol_pkg::ST_W-1:0]  out_status,
  output logic             [pol_pkg::CNT_W-1:0] out_count_out
);

  localparam int N = pol_pkg::CAPACITY;

  logic                      accept;
  logic [pol_pkg::CNT_W-1:0] count_r;
  logic [pol_pkg::CNT_W-1:0] count_nxt;
  pol_pkg::pol_ctl_t         dec_ctl;
  pol_pkg::pol_ctl_t         row_ctl;
  logic                      is_remove;
  logic [pol_pkg::ST_W-1:0]  status;
  logic [pol_pkg::VAL_W-1:0] cell_data [N];
  logic [pol_pkg::VAL_W-1:0] res_value;
  logic                      out_valid_r;
  logic [pol_pkg::VAL_W-1:0] out_value_r;
  logic [pol_pkg::ST_W-1:0]  out_status_r;
  logic [pol_pkg::CNT_W-1:0] out_count_r;

  // Handshake: the result register frees up when it is empty or being taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Command decode
  pol_ctrl u_ctrl (
    .cmd       (in_cmd),
    .position  (in_position),
    .count     (count_r),
    .ctl       (dec_ctl),
    .is_remove (is_remove),
    .status    (status),
    .count_nxt (count_nxt)
  );

  // Row only moves on an accepted beat
  always_comb begin
    row_ctl     = dec_ctl;
    row_ctl.ins = dec_ctl.ins && accept;
    row_ctl.rem = dec_ctl.rem && accept;
  end

  // Cell row; end cells see zero past the edge
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [pol_pkg::VAL_W-1:0] left_d;
    logic [pol_pkg::VAL_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk        (clk),
      .cell_idx   (pol_pkg::IDX_W'(i)),
      .ctl        (row_ctl),
      .ins_value  (in_value_in),
      .left_data  (left_d),
      .right_data (right_d),
      .data_r     (cell_data[i])
    );
  end

  // Result value: removed entry, -1 on failed remove, zero otherwise
  always_comb begin
    if (dec_ctl.rem) begin
      res_value = cell_data[dec_ctl.at];
    end else if (is_remove) begin
      res_value = '1;
    end else begin
      res_value = '0;
    end
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= res_value;
      out_status_r <= status;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count_out = out_count_r;

  // Count never exceeds the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pol_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // Successful insert grows the list by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec_ctl.ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the count");

  // Reported count matches the internal count after each beat
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_count_r == count_r))
    else $error("result count differs from list count");

  // An error status never changes the list length
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status != pol_pkg::ST_OK)) |=> $stable(count_r))
    else $error("failed command changed the count");

endmodule

`default_nettype wire
